/* design/frequency_to_note_cents_assert.svh */
// Assertion macros for the frequency_to_note_cents port checker
`ifndef FREQUENCY_TO_NOTE_CENTS_ASSERT_SVH
`define FREQUENCY_TO_NOTE_CENTS_ASSERT_SVH

// same-cycle implication
`define FNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/fnc_pkg.sv */
// Package for frequency_to_note_cents: widths, constants, pipeline enables, log table builder
package fnc_pkg;

    localparam int FREQ_FRAC_BITS        = 8;
    localparam int LOG_TABLE_ENTRIES_DEF = 64;

    localparam int FREQ_W  = 24;
    localparam int A4_W    = 18;
    localparam int LOG_W   = 21;
    localparam int ROM_W   = 17;
    localparam int MIDI_W  = 28;
    localparam int NOTE_W  = 7;
    localparam int CENTS_W = 8;

    localparam logic [A4_W-1:0]   A4_RESET       = 18'd112640;
    localparam logic [FREQ_W-1:0] LOW_FREQ_LIMIT = FREQ_W'(10 << FREQ_FRAC_BITS);

    localparam logic [NOTE_W-1:0] NOTE_MIN  = 7'd21;
    localparam logic [NOTE_W-1:0] NOTE_MAX  = 7'd108;
    localparam logic [6:0]        CENTS_MAX = 7'd99;

    typedef struct packed {
        logic s_norm;
        logic s_lookup;
        logic s_log;
        logic s_midi;
        logic s_mult;
        logic s_out;
    } t_pipe_en;

    // log2(y0 / 2^30) in Q16 by repeated squaring; elaboration only
    function automatic logic [ROM_W-1:0] log_rom_entry(input logic [63:0] y0);
        logic [63:0]      y;
        logic [ROM_W-1:0] acc;
        y   = y0;
        acc = '0;
        for (int b = 15; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= 64'h8000_0000) begin
                acc[b] = 1'b1;
                y      = y >> 1;
            end
        end
        return acc;
    endfunction

endpackage

/* design/frequency_to_note_cents.sv */
// Top level: frequency to nearest equal-tempered note, octave and cents
// Throughput: one transfer per cycle unless the output stalls; each stage holds while the next is full and stalled.
// Pipeline: input reg, normalize, table lookup, interpolate, midi, cents product, output reg.
// Reset clears stage valids and sets the A4 reference to 440 Hz; payload regs are not reset.
module frequency_to_note_cents #(
    parameter int LOG_TABLE_ENTRIES = fnc_pkg::LOG_TABLE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [fnc_pkg::FREQ_W-1:0]  i_s_axis_tdata,  // [23:0] frequency
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [15:0]                 o_m_axis_tdata,  // [3:0] note_index, [7:4] octave, [15:8] cents
    output logic [0:0]                  o_m_axis_tuser,  // [0] note_valid
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fnc_pkg::A4_W-1:0]    i_cfg_data
);
    import fnc_pkg::*;

    localparam int STAGES = 7;

    logic [A4_W-1:0]   r_a4;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_ld;
    logic [FREQ_W-1:0] r_freq;
    logic [FREQ_W-1:0] w_a_eff;
    logic              r_low1;
    logic              r_low2;
    logic              r_low3;
    t_pipe_en          w_en;
    logic [LOG_W-1:0]  w_log_f;
    logic [LOG_W-1:0]  w_log_a;
    logic              w_note_valid;
    logic [3:0]        w_note_index;
    logic [3:0]        w_octave;
    logic [CENTS_W-1:0] w_cents;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a4 <= A4_RESET;
        end else if (i_cfg_valid) begin
            r_a4 <= i_cfg_data;
        end
    end

    always_comb begin
        w_ld[STAGES-1] = !r_vld[STAGES-1] || i_m_axis_tready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            w_ld[i] = !r_vld[i] || w_ld[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (w_ld[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_freq <= i_s_axis_tdata;
        end
        if (w_ld[1]) begin
            r_low1 <= (r_freq < LOW_FREQ_LIMIT);
        end
        if (w_ld[2]) begin
            r_low2 <= r_low1;
        end
        if (w_ld[3]) begin
            r_low3 <= r_low2;
        end
    end

    assign w_a_eff = (r_a4 == '0) ? FREQ_W'(1) : FREQ_W'(r_a4);

    assign w_en.s_norm   = w_ld[1];
    assign w_en.s_lookup = w_ld[2];
    assign w_en.s_log    = w_ld[3];
    assign w_en.s_midi   = w_ld[4];
    assign w_en.s_mult   = w_ld[5];
    assign w_en.s_out    = w_ld[6];

    fnc_log2 #(
        .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
    ) u_log_f (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_freq),
        .o_log (w_log_f)
    );

    fnc_log2 #(
        .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
    ) u_log_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_a_eff),
        .o_log (w_log_a)
    );

    fnc_note u_note (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_log_f      (w_log_f),
        .i_log_a      (w_log_a),
        .i_low        (r_low3),
        .o_note_valid (w_note_valid),
        .o_note_index (w_note_index),
        .o_octave     (w_octave),
        .o_cents      (w_cents)
    );

    assign o_s_axis_tready = w_ld[0];
    assign o_m_axis_tvalid = r_vld[STAGES-1];
    assign o_m_axis_tdata  = {w_cents, w_octave, w_note_index};
    assign o_m_axis_tuser  = w_note_valid;

endmodule

/* design/fnc_log2.sv */
// Three-stage fixed-point log2 (Q16): normalize, table lookup, interpolate
module fnc_log2 #(
    parameter int LOG_TABLE_ENTRIES = fnc_pkg::LOG_TABLE_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  fnc_pkg::t_pipe_en         i_en,
    input  logic [fnc_pkg::FREQ_W-1:0] i_x,
    output logic [fnc_pkg::LOG_W-1:0]  o_log
);
    import fnc_pkg::*;

    localparam int IDX_W  = $clog2(LOG_TABLE_ENTRIES);
    localparam int ROM_AW = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int T_W    = 16 + ROM_AW;

    logic [ROM_W-1:0] w_rom [0:LOG_TABLE_ENTRIES];

    genvar g;
    generate
        for (g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_rom
            if (g == LOG_TABLE_ENTRIES) begin : g_top
                assign w_rom[g] = ROM_W'(65536);
            end else begin : g_ent
                localparam logic [63:0] LP_Y0 =
                    ((64'(LOG_TABLE_ENTRIES) + 64'(g)) << 30) / 64'(LOG_TABLE_ENTRIES);
                assign w_rom[g] = log_rom_entry(LP_Y0);
            end
        end
    endgenerate

    // stage 1: leading one and mantissa
    logic [4:0]        w_p;
    logic [FREQ_W-1:0] w_norm;
    logic [4:0]        r_p;
    logic [15:0]       r_frac;

    always_comb begin
        w_p = '0;
        for (int i = 0; i < FREQ_W; i++) begin
            if (i_x[i]) begin
                w_p = 5'(i);
            end
        end
        w_norm = i_x << (5'd23 - w_p);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s_norm) begin
            r_p    <= w_p;
            r_frac <= w_norm[22:7];
        end
    end

    // stage 2: table index and neighbors
    logic [T_W-1:0]    w_t;
    logic [ROM_AW-1:0] w_ilo;
    logic [ROM_AW-1:0] w_ihi;
    logic [ROM_W-1:0]  w_lo;
    logic [ROM_W-1:0]  w_hi;
    logic [4:0]        r_p2;
    logic [ROM_W-1:0]  r_lo;
    logic [ROM_W-1:0]  r_diff;
    logic [15:0]       r_rem;

    always_comb begin
        w_t   = T_W'(r_frac) * T_W'(LOG_TABLE_ENTRIES);
        w_ilo = ROM_AW'(w_t[16 +: IDX_W]);
        w_ihi = w_ilo + ROM_AW'(1);
        w_lo  = w_rom[w_ilo];
        w_hi  = w_rom[w_ihi];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s_lookup) begin
            r_p2   <= r_p;
            r_lo   <= w_lo;
            r_diff <= w_hi - w_lo;
            r_rem  <= w_t[15:0];
        end
    end

    // stage 3: linear interpolation
    logic [33:0]      w_prod;
    logic [ROM_W-1:0] w_interp;
    logic [LOG_W-1:0] r_log;

    always_comb begin
        w_prod   = 34'(r_diff) * 34'(r_rem);
        w_interp = ROM_W'((w_prod + 34'd32768) >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s_log) begin
            r_log <= {r_p2, 16'h0} + LOG_W'(r_lo) + LOG_W'(w_interp);
        end
    end

    assign o_log = r_log;

endmodule

/* design/fnc_note.sv */
// Three-stage note mapper: MIDI value, rounding and cents product, output fields
module fnc_note (
    input  logic                        i_clk,
    input  fnc_pkg::t_pipe_en           i_en,
    input  logic [fnc_pkg::LOG_W-1:0]   i_log_f,
    input  logic [fnc_pkg::LOG_W-1:0]   i_log_a,
    input  logic                        i_low,
    output logic                        o_note_valid,
    output logic [3:0]                  o_note_index,
    output logic [3:0]                  o_octave,
    output logic [fnc_pkg::CENTS_W-1:0] o_cents
);
    import fnc_pkg::*;

    localparam int C_W = 35;
    localparam logic signed [MIDI_W-1:0] MIDI_A4    = MIDI_W'(69 * 65536);
    localparam logic signed [MIDI_W-1:0] MIDI_HALF  = MIDI_W'(32768);
    localparam logic signed [MIDI_W-1:0] MIDI_FLOOR = MIDI_W'(21 * 65536);
    localparam logic [5:0]               RECIP_12   = 6'd43;
    localparam int                       RECIP_SH   = 9;

    // stage 4: midi = 69 + 12 * (log f - log a), Q16
    logic signed [LOG_W:0]    w_d;
    logic signed [MIDI_W-1:0] w_dx;
    logic signed [MIDI_W-1:0] r_midi;
    logic                     r_nv4;

    always_comb begin
        w_d  = $signed({1'b0, i_log_f}) - $signed({1'b0, i_log_a});
        w_dx = MIDI_W'(w_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s_midi) begin
            r_midi <= (w_dx <<< 3) + (w_dx <<< 2) + MIDI_A4;
            r_nv4  <= !i_low;
        end
    end

    // stage 5: nearest note, 100 * residue
    logic signed [MIDI_W-1:0] w_v;
    logic [NOTE_W-1:0]        w_note;
    logic signed [MIDI_W-1:0] w_dm;
    logic signed [C_W-1:0]    w_dmx;
    logic signed [C_W-1:0]    r_c;
    logic [NOTE_W-1:0]        r_note;
    logic                     r_nv5;

    always_comb begin
        w_v = r_midi + MIDI_HALF;
        if (w_v < MIDI_FLOOR) begin
            w_note = NOTE_MIN;
        end else if (w_v[MIDI_W-1:16] > 12'(NOTE_MAX)) begin
            w_note = NOTE_MAX;
        end else begin
            w_note = w_v[16 +: NOTE_W];
        end
        w_dm  = r_midi - $signed(MIDI_W'({w_note, 16'h0}));
        w_dmx = C_W'(w_dm);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s_mult) begin
            r_c    <= (w_dmx <<< 6) + (w_dmx <<< 5) + (w_dmx <<< 2);
            r_note <= w_note;
            r_nv5  <= r_nv4;
        end
    end

    // stage 6: round cents away from zero, clamp, split note
    logic [C_W-1:0]     w_mag;
    logic [C_W-17:0]    w_cr;
    logic [6:0]         w_cl;
    logic [CENTS_W-1:0] w_cents;
    logic [12:0]        w_qx;
    logic [3:0]         w_q;
    logic [NOTE_W-1:0]  w_rem;
    logic               r_nv;
    logic [3:0]         r_idx;
    logic [3:0]         r_oct;
    logic [CENTS_W-1:0] r_cents;

    always_comb begin
        w_mag   = r_c[C_W-1] ? C_W'(-r_c) : C_W'(r_c);
        w_cr    = (C_W-16)'((w_mag + C_W'(32768)) >> 16);
        w_cl    = (w_cr > (C_W-16)'(CENTS_MAX)) ? CENTS_MAX : w_cr[6:0];
        w_cents = r_c[C_W-1] ? -CENTS_W'(w_cl) : CENTS_W'(w_cl);
        w_qx    = 13'(r_note) * 13'(RECIP_12);
        w_q     = w_qx[RECIP_SH +: 4];
        w_rem   = r_note - NOTE_W'(w_q) * NOTE_W'(12);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s_out) begin
            r_nv    <= r_nv5;
            r_idx   <= r_nv5 ? w_rem[3:0] : 4'd0;
            r_oct   <= r_nv5 ? (w_q - 4'd1) : 4'd0;
            r_cents <= r_nv5 ? w_cents : '0;
        end
    end

    assign o_note_valid = r_nv;
    assign o_note_index = r_idx;
    assign o_octave     = r_oct;
    assign o_cents      = r_cents;

endmodule

/* design/fnc_checker.sv */
// Port-level checker for frequency_to_note_cents, with its bind
`include "frequency_to_note_cents_assert.svh"

module fnc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    `FNC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result changed while stalled")
    `FNC_ASSERT_NOW(a_no_note_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata == 16'h0, "no-note result has nonzero fields")
    `FNC_ASSERT_NOW(a_fields_range, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata[3:0] <= 4'd11 && o_m_axis_tdata[7:4] <= 4'd8 && $signed(o_m_axis_tdata[15:8]) >= -8'sd99 && $signed(o_m_axis_tdata[15:8]) <= 8'sd99, "result field out of range")
    `FNC_ASSERT_NOW(a_note_clamp, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], (o_m_axis_tdata[7:4] != 4'd8 || o_m_axis_tdata[3:0] == 4'd0) && (o_m_axis_tdata[7:4] != 4'd0 || o_m_axis_tdata[3:0] >= 4'd9), "note outside A0 to C8")

endmodule

bind frequency_to_note_cents fnc_checker u_fnc_checker (.*);

/* tb/note_checker.sv */
// Checker for frequency_to_note_cents: predicts the nearest note per frequency transfer and compares
`timescale 1ns / 100ps

module note_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [fnc_pkg::FREQ_W-1:0]  i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [15:0]                 i_out_data,
    input  logic [0:0]                  i_out_user,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [fnc_pkg::A4_W-1:0]    i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int TABLE_SIZE = fnc_pkg::LOG_TABLE_ENTRIES_DEF;
    localparam logic [fnc_pkg::FREQ_W-1:0] TEN_HZ =
        fnc_pkg::FREQ_W'(10 << fnc_pkg::FREQ_FRAC_BITS);
    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic       found;
        logic [3:0] pitch;
        logic [3:0] octave;
        logic [7:0] cents;
    } t_note;

    typedef struct packed {
        t_note                      note;
        logic [fnc_pkg::FREQ_W-1:0] freq;
    } t_pending_note;

    longint unsigned          log_table [0:TABLE_SIZE];
    logic [fnc_pkg::A4_W-1:0] a4_ref;
    t_pending_note            expected_notes [$];
    int                       n_errors = 0;
    int                       n_printed = 0;

    assign o_fail_count = n_errors;

    // log2(1 + k/N) in Q16 by repeated squaring of a Q30 value
    initial begin : build_log_table
        longint unsigned y;
        longint unsigned acc;
        for (int k = 0; k <= TABLE_SIZE; k++) begin
            if (k == TABLE_SIZE) begin
                log_table[k] = 65536;
            end else begin
                y   = ((longint'(TABLE_SIZE) + k) << 30) / TABLE_SIZE;
                acc = 0;
                for (int b = 15; b >= 0; b--) begin
                    y = (y * y) >> 30;
                    if (y >= (64'd1 << 31)) begin
                        acc = acc | (64'd1 << b);
                        y   = y >> 1;
                    end
                end
                log_table[k] = acc;
            end
        end
    end

    function automatic longint log2_fixed(input logic [fnc_pkg::FREQ_W-1:0] x);
        int              p;
        longint unsigned xw, frac, t, idx, rem, lo, hi;
        xw = x;
        p  = 23;
        while (p > 0 && x[p] == 1'b0)
            p--;
        frac = ((xw << (31 - p)) >> 15) & 64'hFFFF;
        t    = frac * TABLE_SIZE;
        idx  = t >> 16;
        rem  = t & 64'hFFFF;
        if (idx > TABLE_SIZE - 1)
            idx = TABLE_SIZE - 1;
        lo = log_table[idx];
        hi = log_table[idx + 1];
        return (longint'(p) <<< 16) + longint'(lo) + longint'(((hi - lo) * rem + 32768) >> 16);
    endfunction

    function automatic t_note nearest_note(input logic [fnc_pkg::FREQ_W-1:0] f,
                                           input logic [fnc_pkg::A4_W-1:0] a4);
        t_note  r;
        longint midi, v, note, c, mag, cents, lim;
        r = '0;
        if (f < TEN_HZ)
            return r;
        midi = (longint'(69) <<< 16) +
               12 * (log2_fixed(f) - log2_fixed(fnc_pkg::FREQ_W'((a4 == '0) ? 1 : a4)));
        v = midi + 32768;
        if (v < (longint'(fnc_pkg::NOTE_MIN) <<< 16)) begin
            note = longint'(fnc_pkg::NOTE_MIN);
        end else begin
            note = v >>> 16;
            if (note > longint'(fnc_pkg::NOTE_MAX))
                note = longint'(fnc_pkg::NOTE_MAX);
        end
        c     = 100 * (midi - note * 65536);
        mag   = (c < 0) ? -c : c;
        cents = (mag + 32768) >>> 16;
        if (c < 0)
            cents = -cents;
        lim = longint'(fnc_pkg::CENTS_MAX);
        if (cents < -lim)
            cents = -lim;
        if (cents > lim)
            cents = lim;
        r.found  = 1'b1;
        r.pitch  = 4'(note % 12);
        r.octave = 4'(note / 12 - 1);
        r.cents  = 8'(cents);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_printed < MAX_PRINTED) begin
            $display("%0t ns: %s", $time, msg);
            n_printed++;
        end
        n_errors++;
    endtask

    always @(posedge i_clk) begin : watch
        t_note         got;
        t_pending_note want;
        t_pending_note fresh;
        if (!i_rst_n) begin
            a4_ref = fnc_pkg::A4_RESET;
            expected_notes.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                a4_ref = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                got.found  = i_out_user[0];
                got.pitch  = i_out_data[3:0];
                got.octave = i_out_data[7:4];
                got.cents  = i_out_data[15:8];
                if (expected_notes.size() == 0) begin
                    report_mismatch($sformatf("unexpected note transfer: found=%0d pitch=%0d octave=%0d cents=%0d",
                        got.found, got.pitch, got.octave, $signed(got.cents)));
                end else begin
                    want = expected_notes.pop_front();
                    if (got.found != want.note.found || got.pitch != want.note.pitch ||
                        got.octave != want.note.octave || got.cents != want.note.cents)
                        report_mismatch($sformatf(
                            "freq %0d: got found=%0d pitch=%0d octave=%0d cents=%0d, exp %0d %0d %0d %0d",
                            want.freq, got.found, got.pitch, got.octave, $signed(got.cents),
                            want.note.found, want.note.pitch, want.note.octave,
                            $signed(want.note.cents)));
                end
            end
            if (i_in_valid && i_in_ready) begin
                fresh.note = nearest_note(i_in_data, a4_ref);
                fresh.freq = i_in_data;
                expected_notes.push_back(fresh);
            end
            o_pending <= expected_notes.size();
        end
    end

endmodule

/* tb/tb.sv */
// Testbench top for frequency_to_note_cents: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int N_SETTINGS    = 8;
    localparam int N_PER_SETTING = 53;
    localparam logic [fnc_pkg::FREQ_W-1:0] FREQ_MAX = '1;
    localparam logic [fnc_pkg::FREQ_W-1:0] TEN_HZ   =
        fnc_pkg::FREQ_W'(10 << fnc_pkg::FREQ_FRAC_BITS);

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_s_axis_tvalid = 1'b0;
    logic                       o_s_axis_tready;
    logic [fnc_pkg::FREQ_W-1:0] i_s_axis_tdata = '0;
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready = 1'b0;
    logic [15:0]                o_m_axis_tdata;
    logic [0:0]                 o_m_axis_tuser;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [fnc_pkg::A4_W-1:0]   i_cfg_data = '0;

    int                         tx_idle_pct = 0;
    int                         rx_idle_pct = 0;
    logic [fnc_pkg::A4_W-1:0]   cur_a4 = fnc_pkg::A4_RESET;
    int                         fail_count;
    int                         pending;
    int                         quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    frequency_to_note_cents uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    note_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_ready   (o_s_axis_tready),
        .i_in_data    (i_s_axis_tdata),
        .i_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .i_out_data   (o_m_axis_tdata),
        .i_out_user   (o_m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk)
        i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_freq(input logic [fnc_pkg::FREQ_W-1:0] f);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= f;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic write_a4(input logic [fnc_pkg::A4_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_a4 = v;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [fnc_pkg::FREQ_W-1:0] clamp_freq(input real fr);
        if (fr < 0.0)
            return '0;
        if (fr > 16777215.0)
            return FREQ_MAX;
        return fnc_pkg::FREQ_W'($rtoi(fr));
    endfunction

    // half spread over octaves; also noise, sub-10 Hz, values near the reference and half-step rounding edges
    function automatic logic [fnc_pkg::FREQ_W-1:0] pick_frequency();
        int  sel, p, k;
        real base;
        sel  = $urandom_range(0, 9);
        base = (cur_a4 == '0) ? 1.0 : real'(cur_a4);
        case (sel)
            0:       return fnc_pkg::FREQ_W'($urandom_range(0, TEN_HZ - 1));
            1, 2:    return fnc_pkg::FREQ_W'($urandom);
            8:       return clamp_freq(base + real'(int'($urandom_range(0, 400)) - 200));
            9: begin
                k = int'($urandom_range(0, 110)) - 60;
                return clamp_freq(base * (2.0 ** ((real'(k) + 0.5) / 12.0)) +
                                  real'(int'($urandom_range(0, 8)) - 4));
            end
            default: begin
                p = $urandom_range(11, 23);
                return fnc_pkg::FREQ_W'((1 << p) | ($urandom & ((1 << p) - 1)));
            end
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_pct = 24;
        rx_idle_pct = 77;

        // edges under the reset reference: zero, around 10 Hz, saturation, A4, octaves,
        // half-step rounding boundaries, bit patterns
        send_freq(24'd0);
        send_freq(24'd1);
        send_freq(TEN_HZ - 1);
        send_freq(TEN_HZ);
        send_freq(TEN_HZ + 1);
        send_freq(FREQ_MAX);
        send_freq(24'd112640);
        send_freq(24'd112639);
        send_freq(24'd112641);
        send_freq(24'd56320);
        send_freq(24'd225280);
        send_freq(24'd115941);
        send_freq(24'd115942);
        send_freq(24'd109437);
        send_freq(24'd109438);
        send_freq(24'd7040);
        send_freq(24'd1074053);
        send_freq(24'h800000);
        send_freq(24'h7FFFFF);
        send_freq(24'h555555);
        send_freq(24'hAAAAAA);
        send_freq(24'd66976);

        for (int s = 0; s < N_SETTINGS; s++) begin
            if (s == 3) begin
                tx_idle_pct = 77;
                rx_idle_pct = 24;
            end
            if (s == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (s != 0) begin
                drain();
                case (s)
                    1:       write_a4(18'd25600);
                    2:       write_a4(18'd256000);
                    3:       write_a4(18'd0);
                    4:       write_a4(18'h3FFFF);
                    5:       write_a4(fnc_pkg::A4_W'($urandom_range(25600, 256000)));
                    6:       write_a4(18'd1);
                    default: write_a4(fnc_pkg::A4_RESET);
                endcase
            end
            send_freq(TEN_HZ);
            send_freq(FREQ_MAX);
            send_freq(clamp_freq((cur_a4 == '0) ? 1.0 : real'(cur_a4)));
            repeat (N_PER_SETTING) send_freq(pick_frequency());
        end
        i_s_axis_tvalid <= 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/fnc_pkg.sv
design/fnc_log2.sv
design/fnc_note.sv
design/frequency_to_note_cents.sv
design/fnc_checker.sv
tb/note_checker.sv
tb/tb.sv
